@@ design/dynamic_priority_scheduler_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dynamic priority scheduler
// Concurrent checks on a clock with a reset that disables them.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DPS_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("scheduler assertion failed");
`define DPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
`else
`define DPS_ASSERT(label, clk, rst, expr)
`define DPS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

@@ design/dps_pkg.sv @@
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the dynamic priority scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

   localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_FULL     = 3'd1,
      ST_ZERO     = 3'd2,
      ST_RAN      = 3'd3,
      ST_FINISHED = 3'd4,
      ST_IDLE     = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0]        pid;
      logic [15:0]        req;
      logic [15:0]        used;
      logic signed [15:0] prio;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request beat
      logic execute;   // run the latched item, load the result
      logic place;     // reinsert the held head entry
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reinsert;  // current tick moves the head back into the table
   } stat_type;

endpackage

@@ design/dynamic_priority_scheduler_unit.sv @@
// Timing: an accepted request beat is latched, then executed into the result
//   register, for adds and ticks alike; execution waits while a held result stalls.
// Sequencing: a new beat is taken only once the last has executed, and for a
//   tick that reinserts the head, been placed back; one shift table serves all.
// Reset: clears the entry count, sequencer and result valid; entry contents
//   stay undefined until written. No clearing pass.
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler_unit
// Priority-sorted process table: add processes, run the head one tick at a
// time with a saturating priority drop, and reinsert it behind higher priorities.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_unit #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [15:0]        req_new_pid,
   input  logic [15:0]        req_required_ticks,
   input  logic signed [15:0] req_start_priority,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_ran_pid,
   output logic signed [15:0] rsp_ran_priority,
   output logic [15:0]        rsp_ran_used_ticks,
   output logic [4:0]         rsp_entry_count
);
   import dps_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer: takes a request beat only while idle. The result register
   // sits between the two channels, so a new beat is accepted while the
   // previous result still waits; execution stalls only if it is still held.
   dps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Table: one register cell per slot, sorted by falling priority. An
   // insert compares all cells with the new priority at once and shifts the
   // lower part down by one; a removal shifts everything up by one.
   dps_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_mode           (req_mode),
      .req_new_pid        (req_new_pid),
      .req_required_ticks (req_required_ticks),
      .req_start_priority (req_start_priority),
      .rsp_status         (rsp_status),
      .rsp_ran_pid        (rsp_ran_pid),
      .rsp_ran_priority   (rsp_ran_priority),
      .rsp_ran_used_ticks (rsp_ran_used_ticks),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule

@@ design/dps_datapath.sv @@
// ----------------------------------------------------------------------------
// dps_datapath
// Sorted shift-insert table of process entries, item latch and result beat.
// ----------------------------------------------------------------------------
`include "dynamic_priority_scheduler_unit_assert.svh"
module dps_datapath #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dps_pkg::cmd_type   cmd,
   output dps_pkg::stat_type  stat,
   input  logic               req_mode,
   input  logic [15:0]        req_new_pid,
   input  logic [15:0]        req_required_ticks,
   input  logic signed [15:0] req_start_priority,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_ran_pid,
   output logic signed [15:0] rsp_ran_priority,
   output logic [15:0]        rsp_ran_used_ticks,
   output logic [4:0]         rsp_entry_count
);
   import dps_pkg::*;

   localparam int CW = $clog2(MAX_PROCESSES + 1);

   entry_type          cell_ff [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] ge;
   logic [CW-1:0]      count_ff, count_in;
   entry_type          ins_ff, ins_in;
   logic               mode_ff, mode_in;

   status_type         status_ff, status_in;
   logic [15:0]        pid_ff, pid_in;
   logic signed [15:0] prio_ff, prio_in;
   logic [15:0]        used_ff, used_in;
   logic [4:0]         ecount_ff, ecount_in;

   entry_type          head;
   logic [15:0]        used_inc;
   logic signed [15:0] prio_dec;
   logic               finished, is_empty, is_full, add_ok, reinsert;
   logic               do_insert, do_drop, do_head;
   logic [CW-1:0]      count_final, count_up, count_dn;
   logic [CW+4:0]      count_wide;

   // head entry arithmetic for a tick
   always_comb begin
      head     = cell_ff[0];
      used_inc = head.used + 16'd1;
      finished = used_inc >= head.req;
      prio_dec = (head.prio == PRIO_MIN) ? head.prio : head.prio - 16'sd1;
      is_empty = count_ff == '0;
      is_full  = count_ff == CW'(MAX_PROCESSES);
      add_ok   = !mode_ff && !is_full && (ins_ff.req != 16'd0);
      reinsert = mode_ff && !is_empty && !finished && (count_ff > CW'(1))
                 && (prio_dec <= cell_ff[1].prio);
      do_insert = (cmd.execute && add_ok) || cmd.place;
      do_drop   = cmd.execute && mode_ff && !is_empty && (finished || reinsert);
      do_head   = cmd.execute && mode_ff && !is_empty && !finished && !reinsert;
   end

   assign stat.reinsert = reinsert;

   // one cell per table slot: keep, take the new entry, shift down, shift up or update the head
   for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
      entry_type prev_cell, next_cell, cell_in;
      logic      at_slot;

      assign ge[i] = (CW'(i) < count_ff) && (cell_ff[i].prio > ins_ff.prio);

      if (i == 0) begin : g_first
         assign at_slot   = 1'b1;
         assign prev_cell = ins_ff;
      end else begin : g_rest
         assign at_slot   = ge[i-1];
         assign prev_cell = cell_ff[i-1];
      end

      if (i == MAX_PROCESSES - 1) begin : g_last
         assign next_cell = cell_ff[i];
      end else begin : g_inner
         assign next_cell = cell_ff[i+1];
      end

      always_comb begin
         cell_in = cell_ff[i];
         if (do_insert) begin
            if (!ge[i]) begin
               cell_in = at_slot ? ins_ff : prev_cell;
            end
         end else if (do_drop) begin
            cell_in = next_cell;
         end else if (do_head && (i == 0)) begin
            cell_in.used = used_inc;
            cell_in.prio = prio_dec;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in;
      end
   end

   // item latch, reused to hold the head entry that goes back in
   always_comb begin
      ins_in  = ins_ff;
      mode_in = mode_ff;
      if (cmd.capture) begin
         mode_in     = req_mode;
         ins_in.pid  = req_new_pid;
         ins_in.req  = req_required_ticks;
         ins_in.used = 16'd0;
         ins_in.prio = req_start_priority;
      end else if (cmd.execute && reinsert) begin
         ins_in.pid  = head.pid;
         ins_in.req  = head.req;
         ins_in.used = used_inc;
         ins_in.prio = prio_dec;
      end
   end

   assign count_up = count_ff + CW'(1);
   assign count_dn = count_ff - CW'(1);

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_up;
      end else if (do_drop) begin
         count_in = count_dn;
      end
   end

   // result beat
   always_comb begin
      status_in   = status_ff;
      pid_in      = pid_ff;
      prio_in     = prio_ff;
      used_in     = used_ff;
      count_final = count_ff;
      if (!mode_ff) begin
         pid_in  = 16'd0;
         prio_in = 16'sd0;
         used_in = 16'd0;
         if (is_full) begin
            status_in = ST_FULL;
         end else if (ins_ff.req == 16'd0) begin
            status_in = ST_ZERO;
         end else begin
            status_in   = ST_ADDED;
            count_final = count_ff + CW'(1);
         end
      end else if (is_empty) begin
         status_in = ST_IDLE;
         pid_in    = 16'd0;
         prio_in   = 16'sd0;
         used_in   = 16'd0;
      end else begin
         pid_in  = head.pid;
         used_in = used_inc;
         if (finished) begin
            status_in   = ST_FINISHED;
            prio_in     = head.prio;
            count_final = count_ff - CW'(1);
         end else begin
            status_in = ST_RAN;
            prio_in   = prio_dec;
         end
      end
      count_wide = (CW+5)'(count_final);
      ecount_in  = count_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff  <= ins_in;
      mode_ff <= mode_in;
      if (cmd.execute) begin
         status_ff <= status_in;
         pid_ff    <= pid_in;
         prio_ff   <= prio_in;
         used_ff   <= used_in;
         ecount_ff <= ecount_in;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_ran_pid        = pid_ff;
   assign rsp_ran_priority   = prio_ff;
   assign rsp_ran_used_ticks = used_ff;
   assign rsp_entry_count    = ecount_ff;

   `DPS_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_PROCESSES))
   `DPS_ASSERT_IMPLY(a_insert_grows, clock, reset, $past(do_insert), count_ff == $past(count_up))
   `DPS_ASSERT_IMPLY(a_drop_shrinks, clock, reset, $past(do_drop), count_ff == $past(count_dn))

endmodule

@@ design/dps_ctrl.sv @@
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer: accept a beat, run it, reinsert the head if needed.
// ----------------------------------------------------------------------------
`include "dynamic_priority_scheduler_unit_assert.svh"
module dps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dps_pkg::cmd_type  cmd,
   input  dps_pkg::stat_type stat
);
   import dps_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_PLACE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = req_valid && req_ready;
      cmd.execute = (state_ff == S_EXEC) && slot_free;
      cmd.place   = state_ff == S_PLACE;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the result register is free
            if (slot_free) begin
               state_in = stat.reinsert ? S_PLACE : S_IDLE;
            end
         end
         S_PLACE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DPS_ASSERT_IMPLY(a_place_after_exec, clock, reset, state_ff == S_PLACE, $past(state_ff == S_EXEC))
   `DPS_ASSERT_IMPLY(a_place_has_result, clock, reset, state_ff == S_PLACE, rsp_valid_ff)
   `DPS_ASSERT_IMPLY(a_result_from_exec, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_EXEC))

endmodule
